[design/banked_memory_and_port_decoder_macros.svh]
// assertion macros for the banked memory and port decoder
`ifndef BANKED_MEMORY_AND_PORT_DECODER_MACROS_SVH
`define BANKED_MEMORY_AND_PORT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define BMPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BMPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BMPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define BMPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/bmpd_pkg.sv]
// shared types, constants and helpers for the banked memory and port decoder
package bmpd_pkg;

   localparam int BANK_BYTES = 16384;
   localparam int RAM_BANKS  = 8;

   localparam int ADDR_W    = 16;
   localparam int PHYS_W    = 17;
   localparam int BANK_BITS = $clog2(BANK_BYTES);
   localparam int QTR_W     = ADDR_W + 1 - BANK_BITS;
   localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'(BANK_BYTES - 1);

   // actions
   localparam logic [2:0] ACT_MEM_RD  = 3'd0;
   localparam logic [2:0] ACT_MEM_WR  = 3'd1;
   localparam logic [2:0] ACT_IO_RD   = 3'd2;
   localparam logic [2:0] ACT_IO_WR   = 3'd3;
   localparam logic [2:0] ACT_KEY_SET = 3'd4;

   // targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_ROM  = 2'd1;
   localparam logic [1:0] TGT_RAM  = 2'd2;
   localparam logic [1:0] TGT_IO   = 2'd3;

   // sound chip strobes
   localparam logic [1:0] STB_NONE  = 2'd0;
   localparam logic [1:0] STB_LATCH = 2'd1;
   localparam logic [1:0] STB_WRITE = 2'd2;

   // configuration register indexes
   localparam logic CSR_PAGING_PRESENT = 1'b0;
   localparam logic CSR_SOUND_PRESENT  = 1'b1;

   // port addresses and masks
   localparam logic [15:0] PORT_PAGING    = 16'h7FFD;
   localparam logic [15:0] PORT_AY_LATCH  = 16'hFFFD;
   localparam logic [15:0] AY_DECODE_MASK = 16'hC002;
   localparam logic [15:0] AY_READ_MATCH  = 16'hC000;
   localparam logic [15:0] AY_WRITE_MATCH = 16'h8000;
   localparam logic [7:0]  PORT_JOYSTICK  = 8'h1F;

   typedef struct packed {
      logic [2:0]        action;
      logic [ADDR_W-1:0] address;
      logic [7:0]        data;
      logic [2:0]        key_row;
      logic [7:0]        floating_bus;
      logic [7:0]        sound_read_data;
      logic              tape_bit;
   } req_beat_type;

   // bank number folded into the populated banks
   function automatic logic [2:0] bank_wrap(input logic [2:0] bank);
      logic [3:0] v;
      v = {1'b0, bank};
      for (int i = 0; i < 4; i++) begin
         if (v >= 4'(RAM_BANKS)) begin
            v = v - 4'(RAM_BANKS);
         end
      end
      return v[2:0];
   endfunction

   function automatic logic [PHYS_W-1:0] phys_of(input logic [2:0] bank,
                                                 input logic [ADDR_W-1:0] offset);
      logic [31:0] w;
      w = (32'(bank) << BANK_BITS) | 32'(offset);
      return w[PHYS_W-1:0];
   endfunction

endpackage

[design/bmpd_io_read.sv]
// i/o read data decode: joystick, sound chip, floating bus and keyboard port
module bmpd_io_read
   import bmpd_pkg::*;
(
   input  req_beat_type beat,
   input  logic [7:0]   key_rows [8],
   input  logic         ear_level,
   input  logic         sound_chip_present,
   output logic [7:0]   read_data
);

   logic [7:0] keys;

   always_comb begin
      keys = 8'hFF;
      if (beat.address[7:1] != 7'd0) begin
         for (int i = 0; i < 8; i++) begin
            if (!beat.address[8 + i]) begin
               keys = keys & key_rows[i];
            end
         end
      end
   end

   always_comb begin
      if (beat.address[0]) begin
         if (beat.address[7:0] == PORT_JOYSTICK) begin
            read_data = 8'd0;
         end else if ((beat.address & AY_DECODE_MASK) == AY_READ_MATCH
                      && sound_chip_present) begin
            read_data = beat.sound_read_data;
         end else begin
            read_data = beat.floating_bus;
         end
      end else begin
         // bit 6 carries ear and tape levels
         read_data = {keys[7], ear_level | beat.tape_bit, keys[5:0]};
      end
   end

endmodule

[design/banked_memory_and_port_decoder.sv]
// a result beat is registered, valid in the cycle after its request beat is accepted
// throughput: one request beat per cycle unless stalled; the output register frees while it is taken
// request stall is raised only when a result waits and the result side stalls
// reset: synchronous, active high; paging, border, ear, mic cleared, key rows all
// released, both configuration bits set, no result pending
module banked_memory_and_port_decoder
   import bmpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [7:0]          req_data,
   input  logic [2:0]          req_key_row,
   input  logic [7:0]          req_floating_bus,
   input  logic [7:0]          req_sound_read_data,
   input  logic                req_tape_bit,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_target,
   output logic [PHYS_W-1:0]   rsp_phys_address,
   output logic                rsp_write_enable,
   output logic [7:0]          rsp_io_read_data,
   output logic                rsp_contended,
   output logic [2:0]          rsp_border_colour,
   output logic                rsp_ear_out,
   output logic                rsp_mic_out,
   output logic [2:0]          rsp_display_bank,
   output logic [1:0]          rsp_sound_strobe,
   output logic                rsp_paging_locked,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic                csr_write_data
);

`include "banked_memory_and_port_decoder_macros.svh"

   req_beat_type beat;
   logic         req_accept;

   // configuration
   logic paging_present_ff, sound_present_ff;

   // machine state
   logic       rom_bank_ff, rom_bank_in;
   logic [2:0] ram_bank_ff, ram_bank_in;
   logic       screen_sel_ff, screen_sel_in;
   logic       lock_flag_ff, lock_flag_in;
   logic       ear_level_ff, ear_level_in;
   logic       mic_level_ff, mic_level_in;
   logic [2:0] border_ff, border_in;
   logic [7:0] key_rows_ff [8];

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        target_ff, target_in;
   logic [PHYS_W-1:0] phys_ff, phys_in;
   logic              we_ff, we_in;
   logic [7:0]        rd_ff, rd_in;
   logic              cont_ff, cont_in;
   logic [1:0]        strobe_ff, strobe_in;
   logic [2:0]        border_out_ff;
   logic              ear_out_ff, mic_out_ff, locked_out_ff;
   logic [2:0]        display_ff;

   logic [QTR_W-1:0]  quarter;
   logic [ADDR_W-1:0] offset;
   logic              qtr_valid, qtr_cont;
   logic [2:0]        ram_sel;
   logic [7:0]        io_data;

   assign beat = '{action: req_action, address: req_address, data: req_data,
                   key_row: req_key_row, floating_bus: req_floating_bus,
                   sound_read_data: req_sound_read_data, tape_bit: req_tape_bit};

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign quarter   = QTR_W'({1'b0, req_address} >> BANK_BITS);
   assign offset    = req_address & OFFSET_MASK;
   assign qtr_valid = 32'(quarter) <= 32'd3;
   assign qtr_cont  = (32'(quarter) == 32'd1) || (32'(quarter) == 32'd3 && ram_bank_ff[0]);

   always_comb begin
      case (32'(quarter))
         32'd1:   ram_sel = 3'd5;
         32'd2:   ram_sel = 3'd2;
         default: ram_sel = ram_bank_ff;
      endcase
   end

   bmpd_io_read u_io_read (
      .beat               (beat),
      .key_rows           (key_rows_ff),
      .ear_level          (ear_level_ff),
      .sound_chip_present (sound_present_ff),
      .read_data          (io_data)
   );

   always_comb begin
      target_in     = TGT_NONE;
      phys_in       = '0;
      we_in         = 1'b0;
      rd_in         = 8'd0;
      cont_in       = 1'b0;
      strobe_in     = STB_NONE;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      screen_sel_in = screen_sel_ff;
      lock_flag_in  = lock_flag_ff;
      ear_level_in  = ear_level_ff;
      mic_level_in  = mic_level_ff;
      border_in     = border_ff;
      case (req_action)
         ACT_MEM_RD, ACT_MEM_WR: begin
            cont_in = qtr_valid && qtr_cont;
            if (32'(quarter) == 32'd0) begin
               // rom writes are dropped
               if (req_action == ACT_MEM_RD) begin
                  target_in = TGT_ROM;
                  phys_in   = phys_of({2'b00, rom_bank_ff}, offset);
               end
            end else if (qtr_valid) begin
               target_in = TGT_RAM;
               phys_in   = phys_of(bank_wrap(ram_sel), offset);
               we_in     = req_action == ACT_MEM_WR;
            end
         end
         ACT_IO_RD: begin
            target_in = TGT_IO;
            cont_in   = paging_present_ff && qtr_valid && qtr_cont;
            rd_in     = io_data;
         end
         ACT_IO_WR: begin
            target_in = TGT_IO;
            cont_in   = paging_present_ff && qtr_valid && qtr_cont;
            if (!req_address[0]) begin
               ear_level_in = req_data[4];
               mic_level_in = req_data[3];
               border_in    = req_data[2:0];
            end
            if (req_address == PORT_AY_LATCH && sound_present_ff) begin
               strobe_in = STB_LATCH;
            end
            if ((req_address & AY_DECODE_MASK) == AY_WRITE_MATCH && sound_present_ff) begin
               strobe_in = STB_WRITE;
            end
            if (req_address == PORT_PAGING && !lock_flag_ff) begin
               lock_flag_in  = req_data[5];
               rom_bank_in   = req_data[4];
               ram_bank_in   = req_data[2:0];
               screen_sel_in = req_data[3];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_present_ff <= 1'b1;
         sound_present_ff  <= 1'b1;
         rom_bank_ff       <= 1'b0;
         ram_bank_ff       <= 3'd0;
         screen_sel_ff     <= 1'b0;
         lock_flag_ff      <= 1'b0;
         ear_level_ff      <= 1'b0;
         mic_level_ff      <= 1'b0;
         border_ff         <= 3'd0;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            key_rows_ff[i] <= 8'hFF;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_PAGING_PRESENT) begin
               paging_present_ff <= csr_write_data;
            end
            if (csr_index == CSR_SOUND_PRESENT) begin
               sound_present_ff <= csr_write_data;
            end
         end
         if (req_accept) begin
            rom_bank_ff   <= rom_bank_in;
            ram_bank_ff   <= ram_bank_in;
            screen_sel_ff <= screen_sel_in;
            lock_flag_ff  <= lock_flag_in;
            ear_level_ff  <= ear_level_in;
            mic_level_ff  <= mic_level_in;
            border_ff     <= border_in;
            if (req_action == ACT_KEY_SET) begin
               key_rows_ff[req_key_row] <= req_data;
            end
         end
      end
   end

   // result payload, loaded on each accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         target_ff     <= target_in;
         phys_ff       <= phys_in;
         we_ff         <= we_in;
         rd_ff         <= rd_in;
         cont_ff       <= cont_in;
         strobe_ff     <= strobe_in;
         border_out_ff <= border_in;
         ear_out_ff    <= ear_level_in;
         mic_out_ff    <= mic_level_in;
         locked_out_ff <= lock_flag_in;
         display_ff    <= screen_sel_in ? 3'd7 : 3'd5;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target        = target_ff;
   assign rsp_phys_address  = phys_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_io_read_data  = rd_ff;
   assign rsp_contended     = cont_ff;
   assign rsp_border_colour = border_out_ff;
   assign rsp_ear_out       = ear_out_ff;
   assign rsp_mic_out       = mic_out_ff;
   assign rsp_display_bank  = display_ff;
   assign rsp_sound_strobe  = strobe_ff;
   assign rsp_paging_locked = locked_out_ff;

   `BMPD_ASSERT_NEXT(a_lock_sticks, clock, reset, lock_flag_ff, lock_flag_ff)
   `BMPD_ASSERT_NEXT(a_locked_bank_holds, clock, reset, lock_flag_ff,
                     $stable(ram_bank_ff) && $stable(rom_bank_ff) && $stable(screen_sel_ff))
   `BMPD_ASSERT_SAME(a_write_only_ram, clock, reset, rsp_valid_ff && we_ff,
                     target_ff == TGT_RAM)
   `BMPD_ASSERT_SAME(a_phys_zero_off_memory, clock, reset,
                     rsp_valid_ff && target_ff != TGT_ROM && target_ff != TGT_RAM,
                     phys_ff == '0)

endmodule
